// File: sv/lbis_pkg.sv
// shared types, constants and the back-end micro-sequence for the line bundle solver
// no dependencies
package lbis_pkg;

    localparam int COUNT_BITS = 16;

    // working word of the back end: holds the largest intermediate (shifted numerator)
    localparam int AW    = 192;
    // adjugate entries and the A*x products
    localparam int ADJ_W = 100;

    localparam int NUM_SHIFT   = 28;
    localparam int B_SHIFT     = 29;
    localparam int COST_SHIFT  = 44;
    localparam int X_QBITS     = 32;
    localparam int COST_QBITS  = 48;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_REM = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;
    localparam logic [1:0] ST_IGN  = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
    } req_t;

    typedef struct packed {
        logic        [15:0] line_count;
        logic signed [31:0] mid_x;
        logic signed [31:0] mid_y;
        logic signed [31:0] mid_z;
        logic        [47:0] mean_cost;
        logic        [1:0]  status;
    } res_t;

    // snapshot of the running sums handed from front to back
    typedef struct packed {
        logic [8:0][47:0]      mat;
        logic [2:0][47:0]      pnt;
        logic [63:0]           nrm;
        logic [COUNT_BITS-1:0] cnt;
        logic [1:0]            status;
    } job_t;

    // row and column of a row-major 3x3 index
    localparam logic [1:0] ROW_OF [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] COL_OF [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    // adj[k] = m[P]*m[Q] - m[R]*m[S]
    localparam logic [3:0] ADJ_P [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] ADJ_Q [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] ADJ_R [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] ADJ_S [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    localparam logic [2:0] A_M   = 3'd0;
    localparam logic [2:0] A_ADJ = 3'd1;
    localparam logic [2:0] A_Y   = 3'd2;
    localparam logic [2:0] A_B29 = 3'd3;
    localparam logic [2:0] A_C44 = 3'd4;

    localparam logic [1:0] B_M   = 2'd0;
    localparam logic [1:0] B_B   = 2'd1;
    localparam logic [1:0] B_X   = 2'd2;
    localparam logic [1:0] B_ONE = 2'd3;

    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_ADJ  = 3'd1;
    localparam logic [2:0] D_DET  = 3'd2;
    localparam logic [2:0] D_Y    = 3'd3;
    localparam logic [2:0] D_DIVX = 3'd4;
    localparam logic [2:0] D_DIVC = 3'd5;

    typedef struct packed {
        logic       clr;
        logic       neg;
        logic [2:0] a_sel;
        logic [3:0] a_idx;
        logic [1:0] b_sel;
        logic [3:0] b_idx;
        logic [2:0] dst;
        logic [3:0] d_idx;
    } uop_t;

    // one multiply-accumulate per entry, last entry ends with the cost division
    function automatic uop_t ucode(input logic [5:0] pc);
        uop_t       u;
        logic [3:0] k;
        logic [3:0] n;
        u = '0;
        k = 4'(pc >> 1);
        n = 4'd0;
        if (pc < 6'd18)
        begin
            u.a_sel = A_M;
            u.b_sel = B_M;
            if (!pc[0])
            begin
                u.clr   = 1'b1;
                u.a_idx = ADJ_P[k];
                u.b_idx = ADJ_Q[k];
            end
            else
            begin
                u.neg   = 1'b1;
                u.a_idx = ADJ_R[k];
                u.b_idx = ADJ_S[k];
                u.dst   = D_ADJ;
                u.d_idx = k;
            end
        end
        else if (pc < 6'd21)
        begin
            // det = m0*adj0 + m1*adj3 + m2*adj6
            n       = 4'(pc - 6'd18);
            u.a_sel = A_ADJ;
            u.a_idx = 4'((n << 1) + n);
            u.b_sel = B_M;
            u.b_idx = n;
            u.clr   = (n == 4'd0);
            if (n == 4'd2)
                u.dst = D_DET;
        end
        else if (pc < 6'd30)
        begin
            n       = 4'(pc - 6'd21);
            u.a_sel = A_ADJ;
            u.a_idx = n;
            u.b_sel = B_B;
            u.b_idx = {2'b00, COL_OF[n]};
            u.clr   = (COL_OF[n] == 2'd0);
            if (COL_OF[n] == 2'd2)
            begin
                u.dst   = D_DIVX;
                u.d_idx = {2'b00, ROW_OF[n]};
            end
        end
        else if (pc < 6'd39)
        begin
            n       = 4'(pc - 6'd30);
            u.a_sel = A_M;
            u.a_idx = n;
            u.b_sel = B_X;
            u.b_idx = {2'b00, COL_OF[n]};
            u.clr   = (COL_OF[n] == 2'd0);
            if (COL_OF[n] == 2'd2)
            begin
                u.dst   = D_Y;
                u.d_idx = {2'b00, ROW_OF[n]};
            end
        end
        else if (pc < 6'd45)
        begin
            n       = 4'(pc - 6'd39);
            u.b_sel = B_X;
            u.b_idx = {1'b0, n[3:1]};
            u.a_idx = {1'b0, n[3:1]};
            if (!n[0])
            begin
                u.clr   = (n[3:1] == 3'd0);
                u.a_sel = A_Y;
            end
            else
            begin
                u.neg   = 1'b1;
                u.a_sel = A_B29;
            end
        end
        else if (pc == 6'd45)
        begin
            u.a_sel = A_C44;
            u.b_sel = B_ONE;
            u.dst   = D_DIVC;
        end
        return u;
    endfunction

endpackage

// File: sv/lbis_front.sv
// front end: takes items, updates the running sums, queues sum snapshots
// depends on lbis_pkg
module lbis_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  lbis_pkg::req_t item,
    output lbis_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_take
);
    import lbis_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]            st_reg, st_next;
    logic [3:0]            k_reg;
    logic [8:0][47:0]      mat_reg;
    logic [2:0][47:0]      pnt_reg;
    logic [63:0]           nrm_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    req_t                  item_reg;
    logic [63:0]           nacc_reg;
    logic [1:0]            kind_reg;

    job_t                  q_mem [2];
    logic                  q_wp_reg, q_rp_reg;
    logic [1:0]            q_cnt_reg;

    logic                  accept, ign, q_wr, q_rd;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [1:0]            row, col, pi;
    logic signed [31:0]    ma, mb;
    logic signed [63:0]    prod;
    logic [47:0]           t48;
    logic [63:0]           nsum;

    function automatic logic signed [15:0] dsel(input req_t r, input logic [1:0] i);
        unique case (i)
            2'd0:    return r.dir_x;
            2'd1:    return r.dir_y;
            default: return r.dir_z;
        endcase
    endfunction

    function automatic logic signed [31:0] psel(input req_t r, input logic [1:0] i);
        unique case (i)
            2'd0:    return r.pt_x;
            2'd1:    return r.pt_y;
            default: return r.pt_z;
        endcase
    endfunction

    assign full      = (st_reg != F_IDLE);
    assign accept    = push && (st_reg == F_IDLE);
    assign ign       = (item.op == OP_REM) && (cnt_reg == '0);
    assign cnt_next  = (item.op == OP_REM) ? cnt_reg - 1'b1 : cnt_reg + 1'b1;
    assign q_wr      = (st_reg == F_PUSH) && (q_cnt_reg != 2'd2);
    assign q_rd      = job_take && job_valid;
    assign job_valid = (q_cnt_reg != 2'd0);
    assign job       = q_mem[q_rp_reg];

    // one shared multiplier: nine direction products, then three point squares
    always_comb
    begin
        row = (k_reg < 4'd9) ? ROW_OF[k_reg] : 2'd0;
        col = (k_reg < 4'd9) ? COL_OF[k_reg] : 2'd0;
        pi  = 2'(k_reg - 4'd9);
        if (k_reg < 4'd9)
        begin
            ma = 32'(dsel(item_reg, row));
            mb = 32'(dsel(item_reg, col));
        end
        else
        begin
            ma = psel(item_reg, pi);
            mb = ma;
        end
        prod = ma * mb;
        t48  = ((row == col) ? (48'd1 << NUM_SHIFT) : 48'd0) - prod[47:0];
        nsum = nacc_reg + prod;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            F_IDLE:
                if (accept)
                    st_next = ign ? F_PUSH : F_CALC;
            F_CALC:
                if (k_reg == 4'd11)
                    st_next = F_PUSH;
            F_PUSH:
                if (q_wr)
                    st_next = F_IDLE;
            default:
                st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= F_IDLE;
            k_reg     <= '0;
            mat_reg   <= '0;
            pnt_reg   <= '0;
            nrm_reg   <= '0;
            cnt_reg   <= '0;
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept)
            begin
                k_reg <= '0;
                if (!ign)
                begin
                    cnt_reg <= cnt_next;
                    if (item.op == OP_REM)
                    begin
                        pnt_reg[0] <= pnt_reg[0] - 48'(item.pt_x);
                        pnt_reg[1] <= pnt_reg[1] - 48'(item.pt_y);
                        pnt_reg[2] <= pnt_reg[2] - 48'(item.pt_z);
                    end
                    else
                    begin
                        pnt_reg[0] <= pnt_reg[0] + 48'(item.pt_x);
                        pnt_reg[1] <= pnt_reg[1] + 48'(item.pt_y);
                        pnt_reg[2] <= pnt_reg[2] + 48'(item.pt_z);
                    end
                end
            end
            else if (st_reg == F_CALC)
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg < 4'd9)
                    mat_reg[k_reg] <= (item_reg.op == OP_REM) ? mat_reg[k_reg] - t48
                                                              : mat_reg[k_reg] + t48;
                if (k_reg == 4'd11)
                    nrm_reg <= (item_reg.op == OP_REM) ? nrm_reg - (nsum >> 16)
                                                       : nrm_reg + (nsum >> 16);
            end
            if (q_wr)
                q_wp_reg <= ~q_wp_reg;
            if (q_rd)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_wr} - {1'b0, q_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            nacc_reg <= '0;
            if (ign)
                kind_reg <= ST_IGN;
            else
                kind_reg <= (cnt_next < COUNT_BITS'(2)) ? ST_FEW : ST_OK;
        end
        else if (st_reg == F_CALC && k_reg >= 4'd9)
            nacc_reg <= nsum;
        if (q_wr)
            q_mem[q_wp_reg] <= '{mat: mat_reg, pnt: pnt_reg, nrm: nrm_reg,
                                 cnt: cnt_reg, status: kind_reg};
    end

endmodule

// File: sv/lbis_back.sv
// back end: adjugate, determinant, point and cost on a shared 4-bit digit
// multiply-accumulate unit and a bit-serial divider, plus the result queue
// depends on lbis_pkg
module lbis_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lbis_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_take,
    output lbis_pkg::res_t result,
    output logic           empty,
    input  logic           pop
);
    import lbis_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_LOADA = 3'd1;
    localparam logic [2:0] B_LOADB = 3'd2;
    localparam logic [2:0] B_MUL   = 3'd3;
    localparam logic [2:0] B_DIV   = 3'd4;
    localparam logic [2:0] B_DONE  = 3'd5;

    logic [2:0]               st_reg, st_next;
    logic [5:0]               pc_reg, pc_next;

    logic [8:0][47:0]         m_reg;
    logic [2:0][47:0]         bv_reg;
    logic [63:0]              c_reg;
    logic [COUNT_BITS-1:0]    cnt_reg;
    logic [15:0]              lc_reg;
    logic [1:0]               status_reg;
    logic signed [ADJ_W-1:0]  adj_reg [9];
    logic signed [ADJ_W-1:0]  y_reg [3];
    logic [AW-1:0]            det_reg;
    logic                     sing_reg;
    logic signed [31:0]       x_reg [3];
    logic [47:0]              cost_reg;

    logic [AW-1:0]            areg_reg, acc_reg;
    logic [47:0]              breg_reg;
    logic                     bneg_reg;

    logic [AW-1:0]            rem_reg, dsh_reg;
    logic [48:0]              q_reg;
    logic [5:0]               dcnt_reg;
    logic                     dneg_reg;

    res_t                     res_mem [2];
    logic                     wp_reg, rp_reg;
    logic [1:0]               rcnt_reg;

    uop_t                     u;
    logic [3:0]               rd_idx;
    logic signed [47:0]       m_rd, b_rd, b_val;
    logic [AW-1:0]            a_val, prod, nsig, dabs;
    logic [47:0]              b_mag;
    logic                     fin, dfin, ge, res_wr, res_rd;
    logic [48:0]              q_new;
    logic [32:0]              xmag, xlim, xsat;
    logic signed [31:0]       x_new;
    logic [47:0]              cost_new;
    res_t                     res_new;

    assign u      = ucode(pc_reg);
    // one read port on the operand stores: A address then B address
    assign rd_idx = (st_reg == B_LOADA) ? u.a_idx : u.b_idx;

    always_comb
    begin
        m_rd = (rd_idx < 4'd9) ? $signed(m_reg[rd_idx]) : 48'sd0;
        unique case (rd_idx[1:0])
            2'd0:    b_rd = $signed(bv_reg[0]);
            2'd1:    b_rd = $signed(bv_reg[1]);
            default: b_rd = $signed(bv_reg[2]);
        endcase

        unique case (u.a_sel)
            A_M:     a_val = AW'(m_rd);
            A_ADJ:   a_val = AW'(adj_reg[u.a_idx]);
            A_Y:     a_val = AW'(y_reg[u.a_idx[1:0]]);
            A_B29:   a_val = AW'(b_rd) << B_SHIFT;
            A_C44:   a_val = AW'(c_reg) << COST_SHIFT;
            default: a_val = '0;
        endcase

        unique case (u.b_sel)
            B_M:     b_val = m_rd;
            B_B:     b_val = b_rd;
            B_X:     b_val = 48'(x_reg[rd_idx[1:0]]);
            default: b_val = 48'sd1;
        endcase
        b_mag = b_val[47] ? 48'(-b_val) : 48'(b_val);

        prod = areg_reg * {{(AW-4){1'b0}}, breg_reg[3:0]};

        nsig = acc_reg << NUM_SHIFT;
        dabs = det_reg[AW-1] ? -det_reg : det_reg;

        ge    = (rem_reg >= dsh_reg);
        q_new = {q_reg[47:0], ge};
        xmag  = {1'b0, q_new[31:0]};
        xlim  = dneg_reg ? 33'h1_0000_0000 >> 1 : (33'h1_0000_0000 >> 1) - 33'd1;
        xsat  = (q_new[X_QBITS] || xmag > xlim) ? xlim : xmag;
        x_new = dneg_reg ? -$signed(xsat[31:0]) : $signed(xsat[31:0]);
        cost_new = q_new[COST_QBITS] ? {48{1'b1}} : q_new[47:0];

        fin  = (st_reg == B_MUL) && (breg_reg == '0);
        dfin = (st_reg == B_DIV) && (dcnt_reg == '0);
    end

    always_comb
    begin
        st_next  = st_reg;
        pc_next  = pc_reg;
        job_take = 1'b0;
        res_wr   = 1'b0;
        unique case (st_reg)
            B_IDLE:
                if (job_valid && rcnt_reg != 2'd2)
                begin
                    job_take = 1'b1;
                    pc_next  = '0;
                    st_next  = (job.status == ST_OK) ? B_LOADA : B_DONE;
                end
            B_LOADA:
                st_next = B_LOADB;
            B_LOADB:
                st_next = B_MUL;
            B_MUL:
                if (fin)
                begin
                    if (u.dst == D_DIVX && !sing_reg)
                        st_next = B_DIV;
                    else if (u.dst == D_DIVC)
                        st_next = acc_reg[AW-1] ? B_DONE : B_DIV;
                    else
                    begin
                        pc_next = pc_reg + 6'd1;
                        st_next = B_LOADA;
                    end
                end
            B_DIV:
                if (dfin)
                begin
                    if (u.dst == D_DIVC)
                        st_next = B_DONE;
                    else
                    begin
                        pc_next = pc_reg + 6'd1;
                        st_next = B_LOADA;
                    end
                end
            B_DONE:
            begin
                res_wr  = 1'b1;
                st_next = B_IDLE;
            end
            default:
                st_next = B_IDLE;
        endcase
    end

    assign res_rd = pop && !empty;
    assign empty  = (rcnt_reg == 2'd0);
    assign result = res_mem[rp_reg];

    always_comb
    begin
        res_new.line_count = lc_reg;
        res_new.mid_x      = x_reg[0];
        res_new.mid_y      = x_reg[1];
        res_new.mid_z      = x_reg[2];
        res_new.mean_cost  = cost_reg;
        if (status_reg != ST_OK)
            res_new.status = status_reg;
        else
            res_new.status = sing_reg ? ST_SING : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            pc_reg   <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            rcnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            pc_reg <= pc_next;
            if (res_wr)
                wp_reg <= ~wp_reg;
            if (res_rd)
                rp_reg <= ~rp_reg;
            rcnt_reg <= rcnt_reg + {1'b0, res_wr} - {1'b0, res_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            m_reg      <= job.mat;
            bv_reg     <= job.pnt;
            c_reg      <= job.nrm;
            cnt_reg    <= job.cnt;
            lc_reg     <= 16'(job.cnt);
            status_reg <= job.status;
            x_reg[0]   <= '0;
            x_reg[1]   <= '0;
            x_reg[2]   <= '0;
            cost_reg   <= '0;
        end

        if (st_reg == B_LOADA)
        begin
            areg_reg <= a_val;
            if (u.clr)
                acc_reg <= '0;
        end

        if (st_reg == B_LOADB)
        begin
            breg_reg <= b_mag;
            bneg_reg <= u.neg ^ b_val[47];
        end

        if (st_reg == B_MUL && !fin)
        begin
            acc_reg  <= bneg_reg ? acc_reg - prod : acc_reg + prod;
            areg_reg <= areg_reg << 4;
            breg_reg <= breg_reg >> 4;
        end

        if (fin)
        begin
            unique case (u.dst)
                D_ADJ:
                    adj_reg[u.d_idx] <= $signed(acc_reg[ADJ_W-1:0]);
                D_DET:
                begin
                    det_reg  <= acc_reg;
                    sing_reg <= (acc_reg == '0);
                end
                D_Y:
                    y_reg[u.d_idx[1:0]] <= $signed(acc_reg[ADJ_W-1:0]);
                D_DIVX:
                    if (sing_reg)
                        x_reg[u.d_idx[1:0]] <= '0;
                    else
                    begin
                        rem_reg  <= nsig[AW-1] ? -nsig : nsig;
                        dsh_reg  <= dabs << X_QBITS;
                        dneg_reg <= nsig[AW-1] ^ det_reg[AW-1];
                        q_reg    <= '0;
                        dcnt_reg <= 6'(X_QBITS);
                    end
                D_DIVC:
                    // a negative total gives zero cost, already cleared at job start
                    if (!acc_reg[AW-1])
                    begin
                        rem_reg  <= acc_reg;
                        dsh_reg  <= AW'(cnt_reg) << (COST_SHIFT + COST_QBITS);
                        dneg_reg <= 1'b0;
                        q_reg    <= '0;
                        dcnt_reg <= 6'(COST_QBITS);
                    end
                default:
                begin
                end
            endcase
        end

        if (st_reg == B_DIV)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= q_new;
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dfin)
            begin
                if (u.dst == D_DIVC)
                    cost_reg <= cost_new;
                else
                    x_reg[u.d_idx[1:0]] <= x_new;
            end
        end

        if (res_wr)
            res_mem[wp_reg] <= res_new;
    end

endmodule

// File: sv/line_bundle_intersection_solver_unit.sv
// top level of the 3D line bundle least-squares intersection solver
// depends on lbis_pkg, lbis_front, lbis_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | push / full          | item   (op, dir_x/y/z, pt_x/y/z)
//   result   | pop / empty          | result (line_count, mid_x/y/z,
//            |                      |         mean_cost, status)
//
// front end is full until a snapshot is queued (one shared 32x32 multiplier, 12 products)
// back end: the time for a result with a point is set by 46 products on the
// 4-bit digit multiply-accumulate unit and the bit-serial divider (three 33-step
// divisions and one 49-step); too few lines or ignored remove skip both
// two sum snapshots queue between front and back, two results queue at the output
// reset clears the sums, the count and both queues at once; no clearing pass
module line_bundle_intersection_solver_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lbis_pkg::req_t item,
    output logic           empty,
    input  logic           pop,
    output lbis_pkg::res_t result
);
    import lbis_pkg::*;

    job_t job;
    logic job_valid;
    logic job_take;

    lbis_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    lbis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// File: sv/lbis_checker.sv
// port-level checks for the line bundle solver, bound to the top level
// depends on lbis_pkg
module lbis_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input lbis_pkg::res_t result
);
    import lbis_pkg::*;

    logic [3:0] outst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outst_reg <= '0;
        else
            outst_reg <= outst_reg + {3'd0, push && !full} - {3'd0, pop && !empty};
    end

    // a result only ever follows a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outst_reg != 4'd0)
        else $error("result shown with no request outstanding");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result.status == ST_FEW || result.status == ST_IGN) |->
        result.mid_x == 0 && result.mid_y == 0 && result.mid_z == 0 &&
        result.mean_cost == 0)
        else $error("short status with nonzero point or cost");

    a_ign_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status == ST_IGN |-> result.line_count == 16'd0)
        else $error("ignored remove with lines held");

endmodule

bind line_bundle_intersection_solver_unit lbis_checker u_lbis_checker (.*);
